>>> sv/qa_pkg.sv
// qa_pkg: shared types, constants and codes for the quaternion ALU.
// Used by qa_front, qa_back, quaternion_alu and the bench; depends on nothing.
package qa_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	// four products summed with sign: two guard bits keep the sum exact
	localparam int SUM_W     = PROD_W + 2;
	localparam int VAL_W     = SUM_W + 1;
	localparam int NCOMP     = 4;
	localparam int NLANE     = 4;
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);
	localparam int QCW       = $clog2(QDEPTH + 1);

	localparam logic [VAL_W-1:0]  ONE_VAL = VAL_W'(1) << FRAC_BITS;
	localparam logic [DATA_W-1:0] ONE_FX  = DATA_W'(1) << FRAC_BITS;
	localparam logic [DATA_W-1:0] INT_ONE = DATA_W'(1);

	typedef logic signed [DATA_W-1:0] fx_t;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_ADD  = 2'd1,
		OP_CONJ = 2'd2,
		OP_MAT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SH_FRAC    = 2'd0,
		SH_FRAC_M1 = 2'd1,
		SH_NONE    = 2'd2
	} shift_t;

	typedef struct packed {
		op_t  op;
		logic multi;
		fx_t  aw;
		fx_t  ax;
		fx_t  ay;
		fx_t  az;
		fx_t  bw;
		fx_t  bx;
		fx_t  by;
		fx_t  bz;
	} item_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		fx_t  x;
		fx_t  y;
		logic neg;
	} lane_t;

	typedef struct packed {
		lane_t [NLANE-1:0] lanes;
		shift_t            sh;
		logic              one_minus;
	} comp_t;

endpackage

>>> sv/qa_front.sv
// qa_front: accepts input words, tags them and holds them in a small queue.
// Depends on qa_pkg.
module qa_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	output logic            op_stall,
	input  logic [1:0]      opcode,
	input  qa_pkg::fx_t     a_w,
	input  qa_pkg::fx_t     a_x,
	input  qa_pkg::fx_t     a_y,
	input  qa_pkg::fx_t     a_z,
	input  qa_pkg::fx_t     b_w,
	input  qa_pkg::fx_t     b_x,
	input  qa_pkg::fx_t     b_y,
	input  qa_pkg::fx_t     b_z,
	input  logic            pop,
	output qa_pkg::q_head_t head
);
	import qa_pkg::*;

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	item_t          new_item;
	logic           push;

	always_comb begin
		new_item.op    = op_t'(opcode);
		new_item.multi = (op_t'(opcode) == OP_MAT);
		new_item.aw    = a_w;
		new_item.ax    = a_x;
		new_item.ay    = a_y;
		new_item.az    = a_z;
		new_item.bw    = b_w;
		new_item.bx    = b_x;
		new_item.by    = b_y;
		new_item.bz    = b_z;
	end

	assign op_stall   = (cnt_q == QCW'(QDEPTH));
	assign push       = op_valid && !op_stall;
	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/qa_back.sv
// qa_back: issues result words from the queue head (four columns for a matrix),
// then multiplies, sums, shifts and saturates in four stages. Depends on qa_pkg.
module qa_back (
	input  logic            clk,
	input  logic            arst_n,
	input  qa_pkg::q_head_t head,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_stall,
	output qa_pkg::fx_t     r0,
	output qa_pkg::fx_t     r1,
	output qa_pkg::fx_t     r2,
	output qa_pkg::fx_t     r3,
	output logic [1:0]      column,
	output logic            last,
	output logic            saturated
);
	import qa_pkg::*;

	function automatic lane_t ln(input fx_t x, input fx_t y, input logic n);
		lane_t l;
		l.x   = x;
		l.y   = y;
		l.neg = n;
		return l;
	endfunction

	function automatic comp_t mk(input lane_t l0, input lane_t l1, input lane_t l2,
			input lane_t l3, input shift_t sh, input logic om);
		comp_t c;
		c.lanes     = {l3, l2, l1, l0};
		c.sh        = sh;
		c.one_minus = om;
		return c;
	endfunction

	logic        adv;
	logic        issue;
	logic [1:0]  col_q;
	logic        is_last;
	comp_t       sel [NCOMP];
	lane_t       lz;
	fx_t         one_i;
	item_t       it;

	// stage 1: selected operands
	comp_t       c_s1 [NCOMP];
	logic [1:0]  col_s1;
	logic        last_s1;
	logic        v_s1;
	// stage 2: products
	logic signed [PROD_W-1:0] prod_s2 [NCOMP][NLANE];
	logic [NLANE-1:0]         neg_s2 [NCOMP];
	shift_t      sh_s2 [NCOMP];
	logic        om_s2 [NCOMP];
	logic [1:0]  col_s2;
	logic        last_s2;
	logic        v_s2;
	// stage 3: exact sums
	logic signed [SUM_W-1:0]  sum_s3 [NCOMP];
	shift_t      sh_s3 [NCOMP];
	logic        om_s3 [NCOMP];
	logic [1:0]  col_s3;
	logic        last_s3;
	logic        v_s3;
	// stage 4: output word
	fx_t         r_s4 [NCOMP];
	logic        sat_s4;
	logic [1:0]  col_s4;
	logic        last_s4;
	logic        v_s4;

	logic signed [SUM_W-1:0]  acc [NCOMP];
	fx_t         res [NCOMP];
	logic [NCOMP-1:0]         clamp;

	assign adv     = !(v_s4 && res_stall);
	assign issue   = head.valid && adv;
	assign it      = head.item;
	assign is_last = !it.multi || (col_q == 2'd3);
	assign pop     = issue && is_last;
	assign lz      = ln('0, '0, 1'b0);
	assign one_i   = fx_t'(INT_ONE);

	// operand routing per component; add and conjugate go through the
	// multipliers as a product with one and no shift
	always_comb begin
		for (int j = 0; j < NCOMP; j++) begin
			sel[j] = mk(lz, lz, lz, lz, SH_NONE, 1'b0);
		end
		case (it.op)
			OP_MUL: begin
				sel[0] = mk(ln(it.aw, it.bw, 1'b0), ln(it.ax, it.bx, 1'b1),
					ln(it.ay, it.by, 1'b1), ln(it.az, it.bz, 1'b1), SH_FRAC, 1'b0);
				sel[1] = mk(ln(it.aw, it.bx, 1'b0), ln(it.ax, it.bw, 1'b0),
					ln(it.ay, it.bz, 1'b0), ln(it.az, it.by, 1'b1), SH_FRAC, 1'b0);
				sel[2] = mk(ln(it.aw, it.by, 1'b0), ln(it.ay, it.bw, 1'b0),
					ln(it.az, it.bx, 1'b0), ln(it.ax, it.bz, 1'b1), SH_FRAC, 1'b0);
				sel[3] = mk(ln(it.aw, it.bz, 1'b0), ln(it.az, it.bw, 1'b0),
					ln(it.ax, it.by, 1'b0), ln(it.ay, it.bx, 1'b1), SH_FRAC, 1'b0);
			end
			OP_ADD: begin
				sel[0] = mk(ln(it.aw, one_i, 1'b0), ln(it.bw, one_i, 1'b0), lz, lz,
					SH_NONE, 1'b0);
				sel[1] = mk(ln(it.ax, one_i, 1'b0), ln(it.bx, one_i, 1'b0), lz, lz,
					SH_NONE, 1'b0);
				sel[2] = mk(ln(it.ay, one_i, 1'b0), ln(it.by, one_i, 1'b0), lz, lz,
					SH_NONE, 1'b0);
				sel[3] = mk(ln(it.az, one_i, 1'b0), ln(it.bz, one_i, 1'b0), lz, lz,
					SH_NONE, 1'b0);
			end
			OP_CONJ: begin
				sel[0] = mk(ln(it.aw, one_i, 1'b0), lz, lz, lz, SH_NONE, 1'b0);
				sel[1] = mk(ln(it.ax, one_i, 1'b1), lz, lz, lz, SH_NONE, 1'b0);
				sel[2] = mk(ln(it.ay, one_i, 1'b1), lz, lz, lz, SH_NONE, 1'b0);
				sel[3] = mk(ln(it.az, one_i, 1'b1), lz, lz, lz, SH_NONE, 1'b0);
			end
			OP_MAT: begin
				case (col_q)
					2'd0: begin
						sel[0] = mk(ln(it.ay, it.ay, 1'b0), ln(it.az, it.az, 1'b0), lz, lz,
							SH_FRAC_M1, 1'b1);
						sel[1] = mk(ln(it.ax, it.ay, 1'b0), ln(it.aw, it.az, 1'b0), lz, lz,
							SH_FRAC_M1, 1'b0);
						sel[2] = mk(ln(it.ax, it.az, 1'b0), ln(it.aw, it.ay, 1'b1), lz, lz,
							SH_FRAC_M1, 1'b0);
					end
					2'd1: begin
						sel[0] = mk(ln(it.ax, it.ay, 1'b0), ln(it.aw, it.az, 1'b1), lz, lz,
							SH_FRAC_M1, 1'b0);
						sel[1] = mk(ln(it.ax, it.ax, 1'b0), ln(it.az, it.az, 1'b0), lz, lz,
							SH_FRAC_M1, 1'b1);
						sel[2] = mk(ln(it.ay, it.az, 1'b0), ln(it.aw, it.ax, 1'b0), lz, lz,
							SH_FRAC_M1, 1'b0);
					end
					2'd2: begin
						sel[0] = mk(ln(it.ax, it.az, 1'b0), ln(it.aw, it.ay, 1'b0), lz, lz,
							SH_FRAC_M1, 1'b0);
						sel[1] = mk(ln(it.ay, it.az, 1'b0), ln(it.aw, it.ax, 1'b1), lz, lz,
							SH_FRAC_M1, 1'b0);
						sel[2] = mk(ln(it.ax, it.ax, 1'b0), ln(it.ay, it.ay, 1'b0), lz, lz,
							SH_FRAC_M1, 1'b1);
					end
					default: begin
						// last column: only the corner entry, ONE minus nothing
						sel[3] = mk(lz, lz, lz, lz, SH_NONE, 1'b1);
					end
				endcase
			end
			default: ;
		endcase
	end

	// column sequencer and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else if (adv) begin
			if (issue) begin
				col_q <= is_last ? 2'd0 : col_q + 2'd1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		for (int j = 0; j < NCOMP; j++) begin
			acc[j] = '0;
			for (int k = 0; k < NLANE; k++) begin
				if (neg_s2[j][k]) begin
					acc[j] = acc[j] - SUM_W'(prod_s2[j][k]);
				end else begin
					acc[j] = acc[j] + SUM_W'(prod_s2[j][k]);
				end
			end
		end
	end

	always_comb begin
		logic signed [SUM_W-1:0] t;
		logic signed [VAL_W-1:0] v;
		for (int j = 0; j < NCOMP; j++) begin
			case (sh_s3[j])
				SH_FRAC:    t = sum_s3[j] >>> FRAC_BITS;
				SH_FRAC_M1: t = sum_s3[j] >>> (FRAC_BITS - 1);
				default:    t = sum_s3[j];
			endcase
			v = VAL_W'(t);
			if (om_s3[j]) begin
				v = $signed(ONE_VAL) - v;
			end
			// clamp when bit 31 and the bits above it are not all equal
			clamp[j] = !((&v[VAL_W-1:DATA_W-1]) || !(|v[VAL_W-1:DATA_W-1]));
			if (clamp[j]) begin
				res[j] = v[VAL_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
			end else begin
				res[j] = v[DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NCOMP; j++) begin
				c_s1[j]  <= sel[j];
				for (int k = 0; k < NLANE; k++) begin
					prod_s2[j][k] <= PROD_W'($signed(c_s1[j].lanes[k].x))
						* PROD_W'($signed(c_s1[j].lanes[k].y));
					neg_s2[j][k]  <= c_s1[j].lanes[k].neg;
				end
				sh_s2[j]  <= c_s1[j].sh;
				om_s2[j]  <= c_s1[j].one_minus;
				sum_s3[j] <= acc[j];
				sh_s3[j]  <= sh_s2[j];
				om_s3[j]  <= om_s2[j];
				r_s4[j]   <= res[j];
			end
			col_s1  <= it.multi ? col_q : 2'd0;
			last_s1 <= is_last;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
			col_s3  <= col_s2;
			last_s3 <= last_s2;
			col_s4  <= col_s3;
			last_s4 <= last_s3;
			sat_s4  <= |clamp;
		end
	end

	assign res_valid = v_s4;
	assign r0        = r_s4[0];
	assign r1        = r_s4[1];
	assign r2        = r_s4[2];
	assign r3        = r_s4[3];
	assign column    = col_s4;
	assign last      = last_s4;
	assign saturated = sat_s4;

endmodule

>>> sv/quaternion_alu.sv
// quaternion_alu: Q16.16 quaternion multiply, add, conjugate and rotation matrix.
// All ops share one 16-multiplier array, between the operand and the sum stages.
// Throughput: one word per cycle for multiply, add and conjugate unless res_stall holds
// the pipe; a matrix word holds the issue stage while its four columns issue in turn.
// A 4-entry queue sits between intake and the pipeline. Reset (arst_n, async, low)
// empties the queue and the pipeline; no result word is valid after reset.
module quaternion_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_stall,
	input  logic [1:0]  opcode,
	input  qa_pkg::fx_t a_w,
	input  qa_pkg::fx_t a_x,
	input  qa_pkg::fx_t a_y,
	input  qa_pkg::fx_t a_z,
	input  qa_pkg::fx_t b_w,
	input  qa_pkg::fx_t b_x,
	input  qa_pkg::fx_t b_y,
	input  qa_pkg::fx_t b_z,
	output logic        res_valid,
	input  logic        res_stall,
	output qa_pkg::fx_t r0,
	output qa_pkg::fx_t r1,
	output qa_pkg::fx_t r2,
	output qa_pkg::fx_t r3,
	output logic [1:0]  column,
	output logic        last,
	output logic        saturated
);
	import qa_pkg::*;

	q_head_t head;
	logic    pop;

	qa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.opcode   (opcode),
		.a_w      (a_w),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_z      (a_z),
		.b_w      (b_w),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_z      (b_z),
		.pop      (pop),
		.head     (head)
	);

	qa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.r0        (r0),
		.r1        (r1),
		.r2        (r2),
		.r3        (r3),
		.column    (column),
		.last      (last),
		.saturated (saturated)
	);

	// matrix columns leave back to back: a taken non-final word is followed at once by the next
	a_col_seq: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last |=> res_valid && column == $past(column) + 2'd1)
		else $error("matrix column sequence broken");

	// the last column is the constant (0, 0, 0, ONE)
	a_col3: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && column == 2'd3 |-> last && !saturated && r3 == fx_t'(ONE_FX)
			&& r0 == '0 && r1 == '0 && r2 == '0)
		else $error("matrix column 3 wrong");

	// the queue only fills when results are held back or a matrix word is issuing; a stall implies a valid head
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> head.valid)
		else $error("input stalled with empty queue");

endmodule

>>> bench/quaternion_alu_tb.sv
`timescale 1ns / 100ps
// quaternion_alu_tb: self-checking bench for the Q16.16 quaternion unit (all four ops).
// Needs qa_pkg and quaternion_alu; results are checked against typed rows or a local predictor.
module quaternion_alu_tb;
	import qa_pkg::*;

	typedef logic signed [71:0] acc_t;

	typedef struct packed {
		op_t op;
		fx_t aw;
		fx_t ax;
		fx_t ay;
		fx_t az;
		fx_t bw;
		fx_t bx;
		fx_t by;
		fx_t bz;
	} quat_in_t;

	typedef struct packed {
		fx_t        r0;
		fx_t        r1;
		fx_t        r2;
		fx_t        r3;
		logic [1:0] col;
		logic       last;
		logic       sat;
	} res_t;

	typedef struct packed {
		quat_in_t in;
		logic     typed;
		res_t     want;
	} vec_row_t;

	localparam fx_t  ONE = 32'sh0001_0000;
	localparam fx_t  HALF = 32'sh0000_8000;
	localparam fx_t  MX = 32'sh7fff_ffff;
	localparam fx_t  MN = 32'sh8000_0000;
	localparam fx_t  NMX = -32'sd2147483647;
	localparam acc_t FX_MAX = 72'sd2147483647;
	localparam acc_t FX_MIN = -72'sd2147483648;
	localparam acc_t ONE_W = 72'sd1 <<< FRAC_BITS;
	localparam int   QUIET_LIMIT = 1000;
	localparam int   N_RAND = 158;
	localparam int   N_DIR = 22;
	localparam res_t NO_RES = '0;

	// typed rows hold the one result word; the rest go through the predictor
	localparam vec_row_t DIR_ROWS [N_DIR] = '{
		'{'{OP_MUL, ONE, 0, 0, 0, ONE, 0, 0, 0}, 1'b1, '{ONE, 0, 0, 0, 2'd0, 1'b1, 1'b0}},
		'{'{OP_MUL, 0, ONE, 0, 0, 0, 0, ONE, 0}, 1'b1, '{0, 0, 0, ONE, 2'd0, 1'b1, 1'b0}},
		'{'{OP_MUL, 0, 0, ONE, 0, 0, ONE, 0, 0}, 1'b1, '{0, 0, 0, -ONE, 2'd0, 1'b1, 1'b0}},
		'{'{OP_MUL, MX, MX, MX, MX, MX, MX, MX, MX}, 1'b0, NO_RES},
		'{'{OP_MUL, MN, MN, MN, MN, MN, MN, MN, MN}, 1'b0, NO_RES},
		'{'{OP_MUL, MN, MN, MN, MN, MX, MX, MX, MX}, 1'b0, NO_RES},
		'{'{OP_MUL, -1, -1, -1, -1, 1, 1, 1, 1}, 1'b0, NO_RES},
		'{'{OP_MUL, MX, MN, MX, MN, MN, MX, MN, MX}, 1'b0, NO_RES},
		'{'{OP_ADD, MX, MX, MX, MX, MX, MX, MX, MX}, 1'b1, '{MX, MX, MX, MX, 2'd0, 1'b1, 1'b1}},
		'{'{OP_ADD, MN, MN, MN, MN, MN, MN, MN, MN}, 1'b1, '{MN, MN, MN, MN, 2'd0, 1'b1, 1'b1}},
		'{'{OP_ADD, MX, MX, MX, MX, MN, MN, MN, MN}, 1'b1, '{-1, -1, -1, -1, 2'd0, 1'b1, 1'b0}},
		'{'{OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 2'd0, 1'b1, 1'b0}},
		'{'{OP_CONJ, MN, MN, MN, MN, MX, MX, MX, MX}, 1'b1, '{MN, MX, MX, MX, 2'd0, 1'b1, 1'b1}},
		'{'{OP_CONJ, MX, MX, MX, MX, MN, MN, MN, MN}, 1'b1,
			'{MX, NMX, NMX, NMX, 2'd0, 1'b1, 1'b0}},
		'{'{OP_CONJ, ONE, -1, ONE, 0, MX, -7, MN, 3}, 1'b1, '{ONE, 1, -ONE, 0, 2'd0, 1'b1, 1'b0}},
		'{'{OP_MAT, ONE, 0, 0, 0, 0, 0, 0, 0}, 1'b0, NO_RES},
		'{'{OP_MAT, 0, 0, 0, 0, MX, MX, MX, MX}, 1'b0, NO_RES},
		'{'{OP_MAT, MX, MX, MX, MX, 0, 0, 0, 0}, 1'b0, NO_RES},
		'{'{OP_MAT, MN, MN, MN, MN, 0, 0, 0, 0}, 1'b0, NO_RES},
		'{'{OP_MAT, MX, MN, MX, MN, 0, 0, 0, 0}, 1'b0, NO_RES},
		'{'{OP_MAT, HALF, HALF, HALF, HALF, 0, 0, 0, 0}, 1'b0, NO_RES},
		'{'{OP_MAT, 0, ONE, 0, 0, MN, -5, MX, 9}, 1'b0, NO_RES}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic op_valid;
	logic op_stall;
	logic [1:0] opcode;
	fx_t a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
	logic res_valid;
	logic res_stall;
	fx_t r0, r1, r2, r3;
	logic [1:0] column;
	logic last;
	logic saturated;

	res_t due_words[$];
	int   fail_cnt = 0;
	int   quiet_cycles = 0;
	bit   calm = 1'b0;

	quaternion_alu DUT (
		.clk(clk), .arst_n(arst_n),
		.op_valid(op_valid), .op_stall(op_stall), .opcode(opcode),
		.a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.res_valid(res_valid), .res_stall(res_stall),
		.r0(r0), .r1(r1), .r2(r2), .r3(r3),
		.column(column), .last(last), .saturated(saturated)
	);

	always #4 clk = ~clk;

	function automatic acc_t prod(fx_t p, fx_t q);
		acc_t xp, xq;
		xp = p;
		xq = q;
		return xp * xq;
	endfunction

	// floor(2 * (p0 + p1) / 2^FRAC_BITS)
	function automatic acc_t twice_sum(acc_t p0, acc_t p1);
		return (p0 + p1) >>> (FRAC_BITS - 1);
	endfunction

	task automatic queue_word(input acc_t v[4], input logic [1:0] col, input logic fin);
		fx_t  r[4];
		logic f;
		f = 1'b0;
		for (int j = 0; j < 4; j++) begin
			if (v[j] > FX_MAX) begin
				r[j] = MX;
				f = 1'b1;
			end else if (v[j] < FX_MIN) begin
				r[j] = MN;
				f = 1'b1;
			end else begin
				r[j] = v[j][31:0];
			end
		end
		due_words.push_back('{r[0], r[1], r[2], r[3], col, fin, f});
	endtask

	task automatic compute_quat_words(input quat_in_t q);
		acc_t v[4];
		case (q.op)
		OP_MUL: begin
			v[0] = (prod(q.aw, q.bw) - prod(q.ax, q.bx) - prod(q.ay, q.by)
				- prod(q.az, q.bz)) >>> FRAC_BITS;
			v[1] = (prod(q.aw, q.bx) + prod(q.ax, q.bw) + prod(q.ay, q.bz)
				- prod(q.az, q.by)) >>> FRAC_BITS;
			v[2] = (prod(q.aw, q.by) + prod(q.ay, q.bw) + prod(q.az, q.bx)
				- prod(q.ax, q.bz)) >>> FRAC_BITS;
			v[3] = (prod(q.aw, q.bz) + prod(q.az, q.bw) + prod(q.ax, q.by)
				- prod(q.ay, q.bx)) >>> FRAC_BITS;
			queue_word(v, 2'd0, 1'b1);
		end
		OP_ADD: begin
			v[0] = acc_t'(q.aw) + acc_t'(q.bw);
			v[1] = acc_t'(q.ax) + acc_t'(q.bx);
			v[2] = acc_t'(q.ay) + acc_t'(q.by);
			v[3] = acc_t'(q.az) + acc_t'(q.bz);
			queue_word(v, 2'd0, 1'b1);
		end
		OP_CONJ: begin
			v[0] = acc_t'(q.aw);
			v[1] = -acc_t'(q.ax);
			v[2] = -acc_t'(q.ay);
			v[3] = -acc_t'(q.az);
			queue_word(v, 2'd0, 1'b1);
		end
		default: begin
			v[0] = ONE_W - twice_sum(prod(q.ay, q.ay), prod(q.az, q.az));
			v[1] = twice_sum(prod(q.ax, q.ay), prod(q.aw, q.az));
			v[2] = twice_sum(prod(q.ax, q.az), -prod(q.aw, q.ay));
			v[3] = 0;
			queue_word(v, 2'd0, 1'b0);
			v[0] = twice_sum(prod(q.ax, q.ay), -prod(q.aw, q.az));
			v[1] = ONE_W - twice_sum(prod(q.ax, q.ax), prod(q.az, q.az));
			v[2] = twice_sum(prod(q.ay, q.az), prod(q.aw, q.ax));
			queue_word(v, 2'd1, 1'b0);
			v[0] = twice_sum(prod(q.ax, q.az), prod(q.aw, q.ay));
			v[1] = twice_sum(prod(q.ay, q.az), -prod(q.aw, q.ax));
			v[2] = ONE_W - twice_sum(prod(q.ax, q.ax), prod(q.ay, q.ay));
			queue_word(v, 2'd2, 1'b0);
			v[0] = 0;
			v[1] = 0;
			v[2] = 0;
			v[3] = ONE_W;
			queue_word(v, 2'd3, 1'b1);
		end
		endcase
	endtask

	// mostly values near unit scale, with extremes and full-range noise mixed in
	function automatic fx_t rnd_fx();
		case ($urandom_range(9))
		0: return MX;
		1: return MN;
		2, 3: return fx_t'($urandom);
		default: return fx_t'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	task automatic send_word(input quat_in_t q);
		bit taken;
		while (!calm && $urandom_range(99) < 20) begin
			op_valid <= 1'b0;
			@(posedge clk);
		end
		op_valid <= 1'b1;
		opcode <= q.op;
		a_w <= q.aw;
		a_x <= q.ax;
		a_y <= q.ay;
		a_z <= q.az;
		b_w <= q.bw;
		b_x <= q.bx;
		b_y <= q.by;
		b_z <= q.bz;
		do begin
			@(negedge clk);
			taken = !op_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic check_field(input string nm, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", nm, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin
		res_stall <= arst_n && !calm && ($urandom_range(99) < 20);
	end

	// outputs are stable mid-cycle; a word seen here is taken at the next rising edge
	always @(negedge clk) begin : res_check
		res_t due;
		if (arst_n) begin
			if ((op_valid && !op_stall) || (res_valid && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
			if (res_valid && !res_stall) begin
				if (due_words.size() == 0) begin
					$error("result word with no expectation pending");
					fail_cnt++;
				end else begin
					due = due_words.pop_front();
					check_field("r0", due.r0, r0);
					check_field("r1", due.r1, r1);
					check_field("r2", due.r2, r2);
					check_field("r3", due.r3, r3);
					check_field("column", 32'(due.col), 32'(column));
					check_field("last", 32'(due.last), 32'(last));
					check_field("saturated", 32'(due.sat), 32'(saturated));
				end
			end
		end
	end

	initial begin
		quat_in_t q;
		arst_n = 1'b0;
		op_valid = 1'b0;
		opcode = OP_MUL;
		{a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z} = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].typed)
				due_words.push_back(DIR_ROWS[i].want);
			else
				compute_quat_words(DIR_ROWS[i].in);
			send_word(DIR_ROWS[i].in);
		end

		for (int n = 0; n < N_RAND; n++) begin
			// back-to-back stretch on both sides
			calm = (n >= 60 && n < 110);
			q.op = op_t'($urandom_range(3));
			q.aw = rnd_fx();
			q.ax = rnd_fx();
			q.ay = rnd_fx();
			q.az = rnd_fx();
			q.bw = rnd_fx();
			q.bx = rnd_fx();
			q.by = rnd_fx();
			q.bz = rnd_fx();
			compute_quat_words(q);
			send_word(q);
		end
		calm = 1'b0;
		op_valid <= 1'b0;

		while (due_words.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/qa_pkg.sv
sv/qa_front.sv
sv/qa_back.sv
sv/quaternion_alu.sv
bench/quaternion_alu_tb.sv
